>>> hw/rtl/tcv_pkg.sv
// ----------------------------------------------------------------------------
// tcv_pkg: shared types and constants for the transposed convolution block
// Command codes, register indexes, beat payload structs and the request and
// response structs of the shared divider.
// ----------------------------------------------------------------------------
package tcv_pkg;

    localparam int INDEX_W   = 12;
    localparam int VALUE_W   = 16;
    localparam int ACC_W     = 36;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int TAPS_W    = 5;
    localparam int STRIDE_W  = 5;
    localparam int COUNT_W   = 9;

    // offset = index + taps/2 with taps/2 at most 15, so one bit above the index
    localparam int OFFSET_W  = INDEX_W + 1;

    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

    localparam logic [TAPS_W-1:0]   TAPS_RST   = 5'd3;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 5'd2;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd256;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]      out_index;
        logic signed [ACC_W-1:0] out_value;
    } result_t;

    typedef struct packed {
        logic                  start;
        logic [OFFSET_W-1:0]   dividend;
        logic [STRIDE_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [OFFSET_W-1:0]   quotient;
        logic [STRIDE_W-1:0]   remainder;
    } div_rsp_t;

endpackage

>>> hw/rtl/tcv_divider.sv
// ----------------------------------------------------------------------------
// tcv_divider: iterative restoring divider
// One quotient bit per cycle; gives the first tap (remainder) and the first
// source index (quotient) of an output query.
// ----------------------------------------------------------------------------
module tcv_divider (
    input  logic            clk,
    input  logic            rst_n,
    input  tcv_pkg::div_req_t req,
    output tcv_pkg::div_rsp_t rsp
);
    import tcv_pkg::*;

    localparam int CNT_W = $clog2(OFFSET_W + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                done_reg;
    logic                done_next;
    logic [OFFSET_W-1:0] dvd_reg;
    logic [STRIDE_W-1:0] rem_reg;
    logic [STRIDE_W-1:0] dvs_reg;
    logic [STRIDE_W+1:0] trial;
    logic [STRIDE_W:0]   shifted;
    logic                ge;

    assign shifted = {rem_reg, dvd_reg[OFFSET_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = !trial[STRIDE_W+1];

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next = CNT_W'(OFFSET_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift the quotient bit in where the dividend bit leaves
            dvd_reg <= {dvd_reg[OFFSET_W-2:0], ge};
            rem_reg <= ge ? trial[STRIDE_W-1:0] : shifted[STRIDE_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> hw/rtl/tcv_mac.sv
// ----------------------------------------------------------------------------
// tcv_mac: shared multiply-accumulate unit
// Registered product, then a 36-bit accumulate; cleared at each query.
// ----------------------------------------------------------------------------
module tcv_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          in_valid,
    input  logic signed [tcv_pkg::VALUE_W-1:0] weight,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          pend,
    output logic signed [tcv_pkg::ACC_W-1:0]   acc
);
    import tcv_pkg::*;

    localparam int PROD_W = VALUE_W + SAMPLE_BITS;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= weight * sample;
        end
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign pend = prod_valid_reg;
    assign acc  = acc_reg;

endmodule

>>> hw/rtl/transposed_conv1d_output.sv
// Query flow: the bit-serial divider gives the first tap and source index, then
// the walk visits one tap per cycle on the shared MAC, at most ceil(taps/stride)
// taps and at most MAX_TAPS, and the MAC is drained before the done strobe.
// busy stays high while a query runs; weight and sample writes never raise it.
// Results are strobed for one cycle and cannot be stalled; reset clears the
// control state and loads taps 3, stride 2, count 256.
// ----------------------------------------------------------------------------
// transposed_conv1d_output: strided, centered 1-D transposed convolution
// Loads weights and samples, and answers one output index per query by
// walking the contributing taps through a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module transposed_conv1d_output #(
    parameter int MAX_TAPS    = 16,
    parameter int SRC_DEPTH   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tcv_pkg::item_t                  item,
    output logic                            done,
    output tcv_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [tcv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcv_pkg::CFG_W-1:0]       cfg_data
);
    import tcv_pkg::*;

    localparam int TAP_W   = $clog2(MAX_TAPS + 32);
    localparam int WADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SADDR_W = $clog2(SRC_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [TAPS_W-1:0]     taps_cfg_reg;
    logic [STRIDE_W-1:0]   stride_cfg_reg;
    logic [COUNT_W-1:0]    count_cfg_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [INDEX_W-1:0]    idx_next;
    logic [TAP_W-1:0]      k_reg;
    logic [TAP_W-1:0]      k_next;
    logic [STRIDE_W-1:0]   s_reg;
    logic [STRIDE_W-1:0]   s_next;
    logic [TAP_W-1:0]      tap_reg;
    logic [TAP_W-1:0]      tap_next;
    logic [OFFSET_W-1:0]   src_reg;
    logic [OFFSET_W-1:0]   src_next;
    logic                  src_neg_reg;
    logic                  src_neg_next;
    logic                  rd_valid_reg;
    logic                  done_reg;
    logic                  done_next;
    result_t               result_reg;
    result_t               result_next;

    logic [TAP_W-1:0]      k_eff;
    logic [STRIDE_W-1:0]   s_eff;
    logic [OFFSET_W-1:0]   offset;
    logic                  accept;
    logic                  query_go;
    logic                  walk_active;
    logic                  src_in_range;
    logic                  issue;

    logic signed [VALUE_W-1:0]     weight_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] sample_mem [SRC_DEPTH];
    logic signed [VALUE_W-1:0]     w_rd_reg;
    logic signed [SAMPLE_BITS-1:0] s_rd_reg;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic                  mac_pend;
    logic signed [ACC_W-1:0] mac_acc;

    assign accept   = start && !busy;
    assign query_go = accept && (item.cmd == CMD_QUERY);

    // clamp the tap count to 1..MAX_TAPS and the stride to at least 1
    always_comb
    begin
        if (taps_cfg_reg == '0)
        begin
            k_eff = TAP_W'(1);
        end
        else if (32'(taps_cfg_reg) > MAX_TAPS)
        begin
            k_eff = TAP_W'(MAX_TAPS);
        end
        else
        begin
            k_eff = TAP_W'(taps_cfg_reg);
        end
    end

    assign s_eff  = (stride_cfg_reg == '0) ? STRIDE_W'(1) : stride_cfg_reg;
    assign offset = OFFSET_W'(item.index) + OFFSET_W'(k_eff >> 1);

    assign div_req.start    = query_go;
    assign div_req.dividend = offset;
    assign div_req.divisor  = s_eff;

    tcv_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // the walk ends past the last tap or once the source index goes negative
    assign walk_active  = (state_reg == ST_WALK) && (tap_reg < k_reg) && !src_neg_reg;
    assign src_in_range = (src_reg < OFFSET_W'(count_cfg_reg))
                       && (32'(src_reg) < SRC_DEPTH);
    assign issue        = walk_active && src_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_cfg_reg   <= TAPS_RST;
            stride_cfg_reg <= STRIDE_RST;
            count_cfg_reg  <= COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAPS:   taps_cfg_reg   <= cfg_data[TAPS_W-1:0];
                REG_STRIDE: stride_cfg_reg <= cfg_data[STRIDE_W-1:0];
                REG_COUNT:  count_cfg_reg  <= cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.cmd == CMD_WEIGHT) && (32'(item.index) < MAX_TAPS))
        begin
            weight_mem[WADDR_W'(item.index)] <= item.value;
        end
        if (accept && (item.cmd == CMD_SAMPLE) && (32'(item.index) < SRC_DEPTH))
        begin
            sample_mem[SADDR_W'(item.index)] <= SAMPLE_BITS'(item.value);
        end
        if (issue)
        begin
            w_rd_reg <= weight_mem[WADDR_W'(tap_reg)];
            s_rd_reg <= sample_mem[SADDR_W'(src_reg)];
        end
    end

    tcv_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (query_go),
        .in_valid (rd_valid_reg),
        .weight   (w_rd_reg),
        .sample   (s_rd_reg),
        .pend     (mac_pend),
        .acc      (mac_acc)
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        s_next       = s_reg;
        tap_next     = tap_reg;
        src_next     = src_reg;
        src_neg_next = src_neg_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    idx_next   = item.index;
                    k_next     = k_eff;
                    s_next     = s_eff;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    tap_next     = TAP_W'(div_rsp.remainder);
                    src_next     = div_rsp.quotient;
                    src_neg_next = 1'b0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_active)
                begin
                    // next tap is one stride up and one source sample down
                    tap_next = tap_reg + TAP_W'(s_reg);
                    if (src_reg == '0)
                    begin
                        src_neg_next = 1'b1;
                    end
                    else
                    begin
                        src_next = src_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mac_pend)
                begin
                    done_next             = 1'b1;
                    result_next.out_index = idx_reg;
                    result_next.out_value = mac_acc;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            src_neg_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            done_reg     <= done_next;
            src_neg_reg  <= src_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        s_reg      <= s_next;
        tap_reg    <= tap_next;
        src_reg    <= src_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/tcv_checker.sv
// ----------------------------------------------------------------------------
// tcv_checker: port-level checks for the transposed convolution block
// Watches the command beats, busy and the done strobe over time.
// ----------------------------------------------------------------------------
module tcv_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  tcv_pkg::item_t                item,
    input  logic                          done
);
    import tcv_pkg::*;

    // a result beat only appears once the query has finished
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done strobe while busy");

    // one strobe per query, never two in a row
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done strobe held for more than one cycle");

    // an accepted query holds off further beats
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd == CMD_QUERY)) |=> busy)
        else $error("query beat did not raise busy");

    // writes and unused commands finish at once and give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd != CMD_QUERY)) |=> (!busy && !done))
        else $error("non-query beat raised busy or a result");

    // busy ends exactly with the result beat
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

endmodule

bind transposed_conv1d_output tcv_checker u_tcv_checker (.*);

>>> test/tb_transposed_conv1d_output.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transposed_conv1d_output: self-checking bench for the transposed conv block
// Preloads the weight and sample stores, then runs directed beats and several
// register settings of random weight, sample and query beats. A scoreboard
// keeps its own copy of the stores and registers and computes the expected
// output sum for every accepted query.
// ----------------------------------------------------------------------------
module tb_transposed_conv1d_output;
    import tcv_pkg::*;

    localparam int PERIOD          = 20;
    localparam int MAX_TAPS        = 16;
    localparam int SRC_DEPTH       = 256;
    localparam int WADDR_W         = $clog2(MAX_TAPS);
    localparam int SADDR_W         = $clog2(SRC_DEPTH);
    localparam int SETTLE_CYCLES   = 40;
    localparam int LIMIT           = 500000;
    localparam int FIXED_PHASES    = 8;
    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 60;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // register extremes: out-of-range taps and strides, empty and oversized counts
    localparam int TAPS_TAB   [FIXED_PHASES] = '{1, 16, 31, 0, 16, 7, 16, 2};
    localparam int STRIDE_TAB [FIXED_PHASES] = '{1, 1, 31, 0, 16, 17, 3, 5};
    localparam int COUNT_TAB  [FIXED_PHASES] = '{1, 256, 511, 0, 256, 200, 255, 256};

    class conv_scoreboard;
        logic signed [VALUE_W-1:0] weights [MAX_TAPS];
        logic signed [VALUE_W-1:0] samples [SRC_DEPTH];
        logic [TAPS_W-1:0]         taps;
        logic [STRIDE_W-1:0]       stride;
        logic [COUNT_W-1:0]        count;
        result_t                   sums_due [$];
        int                        errors;

        function new();
            taps   = TAPS_RST;
            stride = STRIDE_RST;
            count  = COUNT_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_TAPS:   taps   = data[TAPS_W-1:0];
                REG_STRIDE: stride = data[STRIDE_W-1:0];
                REG_COUNT:  count  = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [ACC_W-1:0] output_sum(logic [INDEX_W-1:0] idx);
            int     k;
            int     s;
            int     n;
            int     offset;
            int     tap;
            int     src;
            longint acc;
            k = taps;
            s = stride;
            n = count;
            if (k < 1)
                k = 1;
            if (k > MAX_TAPS)
                k = MAX_TAPS;
            if (s < 1)
                s = 1;
            if (n > SRC_DEPTH)
                n = SRC_DEPTH;
            offset = idx + k / 2;
            acc = 0;
            for (tap = offset % s; tap < k; tap += s)
            begin
                if (offset - tap < 0)
                    break;
                src = (offset - tap) / s;
                // skip taps that land past the loaded samples
                if (src >= n)
                    continue;
                acc += longint'(weights[WADDR_W'(tap)]) * longint'(samples[SADDR_W'(src)]);
            end
            return acc[ACC_W-1:0];
        endfunction

        function void note_item(item_t it);
            result_t r;
            case (it.cmd)
                CMD_WEIGHT:
                    if (it.index < MAX_TAPS)
                        weights[WADDR_W'(it.index)] = it.value;
                CMD_SAMPLE:
                    if (it.index < SRC_DEPTH)
                        samples[SADDR_W'(it.index)] = it.value;
                CMD_QUERY:
                begin
                    r.out_index = it.index;
                    r.out_value = output_sum(it.index);
                    sums_due.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (sums_due.size() == 0)
            begin
                $error("result with no query pending: out_index=%0d out_value=%0d",
                       got.out_index, got.out_value);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got.out_index !== want.out_index)
            begin
                $error("out_index: expected %0d, actual %0d", want.out_index, got.out_index);
                errors++;
            end
            if (got.out_value !== want.out_value)
            begin
                $error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    conv_scoreboard sb;
    bit             no_gaps = 1'b0;
    int             cycles  = 0;

    transposed_conv1d_output DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("[transposed_conv1d_output] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(result);

    function automatic int pick_gap();
        // toggle now and then into a burst with no idle cycles
        if ($urandom_range(0, 39) == 0)
            no_gaps = !no_gaps;
        return no_gaps ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic item_t make_item(logic [CMD_W-1:0] c, int idx, int val);
        item_t it;
        it.cmd   = c;
        it.index = INDEX_W'(idx);
        it.value = VALUE_W'(val);
        return it;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        int    s;
        int    n;
        int    span;
        pick     = $urandom_range(0, 19);
        it.value = rand_value();
        it.index = INDEX_W'($urandom);
        if (pick < 10)
        begin
            it.cmd = CMD_QUERY;
            s = (sb.stride == 0) ? 1 : sb.stride;
            n = (sb.count > SRC_DEPTH) ? SRC_DEPTH : sb.count;
            span = s * n + MAX_TAPS;
            if (span > 4095)
                span = 4095;
            // keep most queries where samples actually contribute
            if (pick < 8)
                it.index = INDEX_W'($urandom_range(0, span));
        end
        else if (pick < 14)
        begin
            it.cmd = CMD_WEIGHT;
            if (pick < 13)
                it.index = INDEX_W'($urandom_range(0, MAX_TAPS - 1));
        end
        else if (pick < 18)
        begin
            it.cmd = CMD_SAMPLE;
            if (pick < 17)
                it.index = INDEX_W'($urandom_range(0, SRC_DEPTH - 1));
        end
        else
            it.cmd = CMD_UNUSED;
        return it;
    endfunction

    // start stays high across back-to-back beats; drop it only for a gap
    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input int taps, input int stride, input int count);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_W-1:0]     data [4];
        regs = '{REG_TAPS, REG_STRIDE, REG_COUNT, REG_NONE};
        // junk above the register width must be dropped
        data[0] = CFG_W'(($urandom << TAPS_W) | taps);
        data[1] = CFG_W'(($urandom << STRIDE_W) | stride);
        data[2] = CFG_W'(count);
        data[3] = CFG_W'($urandom);
        cfg_we <= 1'b1;
        for (int r = 0; r < 4; r++)
        begin
            cfg_index <= regs[r];
            cfg_data  <= data[r];
            @(posedge clk);
            sb.set_reg(regs[r], data[r]);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        item_t directed [$];
        item_t it;
        int    sent;
        sb        = new();
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_TAPS;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores so no query ever reads a blank entry
        for (int i = 0; i < MAX_TAPS; i++)
            send_item(make_item(CMD_WEIGHT, i, rand_value()));
        for (int i = 0; i < SRC_DEPTH; i++)
            send_item(make_item(CMD_SAMPLE, i, rand_value()));

        directed = '{
            make_item(CMD_WEIGHT, 0, VALUE_MIN),
            make_item(CMD_WEIGHT, 1, VALUE_MIN),
            make_item(CMD_WEIGHT, 2, VALUE_MAX),
            make_item(CMD_SAMPLE, 0, VALUE_MIN),
            make_item(CMD_SAMPLE, 1, VALUE_MAX),
            make_item(CMD_SAMPLE, SRC_DEPTH - 2, VALUE_MAX),
            make_item(CMD_SAMPLE, SRC_DEPTH - 1, VALUE_MIN),
            make_item(CMD_WEIGHT, MAX_TAPS, 16'h1234),
            make_item(CMD_WEIGHT, 4095, -1),
            make_item(CMD_SAMPLE, SRC_DEPTH, 16'h5555),
            make_item(CMD_SAMPLE, 4095, -1),
            make_item(CMD_UNUSED, 4095, -1),
            make_item(CMD_UNUSED, 0, 0),
            make_item(CMD_QUERY, 0, 0),
            make_item(CMD_QUERY, 1, 0),
            make_item(CMD_QUERY, 2, 0),
            make_item(CMD_QUERY, 509, 0),
            make_item(CMD_QUERY, 510, 0),
            make_item(CMD_QUERY, 511, 0),
            make_item(CMD_QUERY, 4095, -1),
            make_item(CMD_QUERY, 0, VALUE_MAX)
        };
        foreach (directed[i])
            send_item(directed[i]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase < FIXED_PHASES)
                load_config(TAPS_TAB[phase], STRIDE_TAB[phase], COUNT_TAB[phase]);
            else
                load_config($urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 511));
            sent = 0;
            while (sent < BEATS_PER_PHASE)
            begin
                it = rand_item();
                send_item(it);
                // beats the block just drops do not count
                if (it.cmd == CMD_QUERY
                    || (it.cmd == CMD_WEIGHT && it.index < MAX_TAPS)
                    || (it.cmd == CMD_SAMPLE && it.index < SRC_DEPTH))
                    sent++;
            end
        end
        drain();

        if (sb.errors == 0)
            $display("[transposed_conv1d_output] OK");
        else
            $display("[transposed_conv1d_output] ERROR");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/tcv_pkg.sv
hw/rtl/tcv_divider.sv
hw/rtl/tcv_mac.sv
hw/rtl/transposed_conv1d_output.sv
hw/rtl/tcv_checker.sv
test/tb_transposed_conv1d_output.sv
